>>> design/tor_pkg.sv
// Shared types, constants and functions for the tag observation to robot pose core.
// No dependencies.
package tor_pkg;

  localparam int CordicStages = 14;
  localparam int TableLen     = 20;
  localparam int NStages      = (CordicStages > TableLen) ? TableLen : CordicStages;

  localparam int ZW = 24;
  localparam int XW = 30;

  localparam logic signed [15:0] PiQ12       = 16'sd12868;
  localparam logic signed [15:0] TwoPiQ12    = 16'sd25736;
  localparam logic signed [ZW-1:0] PiQ20     = 24'sd3294199;
  localparam logic signed [ZW-1:0] HalfPiQ20 = 24'sd1647099;
  localparam logic signed [XW-1:0] GainQ16   = 30'sd39797;
  localparam logic signed [17:0] YawScale    = 18'sd36602;

  typedef enum logic [1:0] {
    REG_KNOWN_ID = 2'd0,
    REG_TAG_X    = 2'd1,
    REG_TAG_Y    = 2'd2,
    REG_TAG_HEAD = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                    valid;
    logic                    known;
    logic signed [15:0]      tx;
    logic signed [15:0]      ty;
    logic signed [15:0]      lat;
    logic signed [15:0]      fwd;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
    logic                    flip;
  } rot_stage_t;

  typedef struct packed {
    logic                    valid;
    logic                    known;
    logic                    zero;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
    logic signed [15:0]      rx;
    logic signed [15:0]      ry;
  } vec_stage_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    case (i)
      0: atan_q20 = 24'sd823550;   1: atan_q20 = 24'sd486170;
      2: atan_q20 = 24'sd256879;   3: atan_q20 = 24'sd130396;
      4: atan_q20 = 24'sd65451;    5: atan_q20 = 24'sd32757;
      6: atan_q20 = 24'sd16383;    7: atan_q20 = 24'sd8192;
      8: atan_q20 = 24'sd4096;     9: atan_q20 = 24'sd2048;
      10: atan_q20 = 24'sd1024;    11: atan_q20 = 24'sd512;
      12: atan_q20 = 24'sd256;     13: atan_q20 = 24'sd128;
      14: atan_q20 = 24'sd64;      15: atan_q20 = 24'sd32;
      16: atan_q20 = 24'sd16;      17: atan_q20 = 24'sd8;
      18: atan_q20 = 24'sd4;       19: atan_q20 = 24'sd2;
      default: atan_q20 = '0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) sat16 = 16'sh7fff;
    else if (v < -20'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

endpackage

>>> design/tor_stream_if.sv
// Valid/ready stream interface carrying one payload word.
// Depends on nothing.
interface tor_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/tag_observation_to_robot_pose_core.sv
// Tag observation to robot pose core: top level with config registers and output stage.
// Depends on tor_pkg, tor_stream_if, tor_front, tor_rotate, tor_position, tor_vector.
//
// Usage: each in_ transaction carries one tag detection {yaw_deg, forward_offset,
// lateral_offset, tag_id} packed MSB first in in_.data. Each out_ transaction returns
// {tag_recognized, bearing_to_tag, robot_x, robot_y} packed MSB first. The cfg_
// channel writes the register with index cfg_.data[50:32] to value cfg_.data[31:0]
// (0 known id, 1 tag x, 2 tag y, 3 tag heading); it is always ready outside reset.
// The path from acceptance to out valid is registered in the front stages, the two
// pipelined CORDIC chains of one stage per iteration, the position stages and the output register.
// Throughput: one transaction per cycle while the receiver does not stall.
// Reset clears all valid bits and loads register defaults (tag x = 2.0 ft).
// When the receiver stalls, the whole pipeline holds; in_.ready drops only in reset
// or while the output register is full and not taken, so nothing is lost or repeated.
// Write configuration only when the pipeline is empty.
module tag_observation_to_robot_pose_core (
  input  logic          clk,
  input  logic          rst_n,
  tor_stream_if.sink    in_,
  tor_stream_if.source  out_,
  tor_stream_if.sink    cfg_
);
  logic [9:0]         known_id_r;
  logic signed [15:0] tag_x_r, tag_y_r;
  logic signed [14:0] tag_h_r;
  logic               en;
  logic               ov_r;
  logic [47:0]        od_r;
  logic signed [tor_pkg::ZW-1:0] zr;
  logic signed [15:0] bear;
  tor_pkg::rot_stage_t f_s, r_s;
  tor_pkg::vec_stage_t p_s, v_s;

  assign en         = !ov_r || out_.ready;
  assign in_.ready  = en && rst_n;
  assign cfg_.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_id_r <= '0;
      tag_x_r    <= 16'sd2048;
      tag_y_r    <= '0;
      tag_h_r    <= '0;
    end else if (cfg_.valid && cfg_.data[50:34] == '0) begin
      case (tor_pkg::reg_idx_t'(cfg_.data[33:32]))
        tor_pkg::REG_KNOWN_ID: known_id_r <= cfg_.data[9:0];
        tor_pkg::REG_TAG_X:    tag_x_r    <= cfg_.data[15:0];
        tor_pkg::REG_TAG_Y:    tag_y_r    <= cfg_.data[15:0];
        tor_pkg::REG_TAG_HEAD: tag_h_r    <= cfg_.data[14:0];
        default: ;
      endcase
    end
  end

  tor_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_.valid),
    .tag_id(in_.data[9:0]), .lat(in_.data[25:10]), .fwd(in_.data[41:26]),
    .yaw(in_.data[58:42]), .known_id(known_id_r), .cfg_tx(tag_x_r),
    .cfg_ty(tag_y_r), .cfg_th(tag_h_r), .out_s(f_s)
  );
  tor_rotate   u_rot (.clk(clk), .rst_n(rst_n), .en(en), .in_s(f_s), .out_s(r_s));
  tor_position u_pos (.clk(clk), .rst_n(rst_n), .en(en), .in_s(r_s), .out_s(p_s));
  tor_vector   u_vec (.clk(clk), .rst_n(rst_n), .en(en), .in_s(p_s), .out_s(v_s));

  always_comb begin
    zr   = (v_s.z + tor_pkg::ZW'(128)) >>> 8;
    bear = 16'(zr);
    if (zr > tor_pkg::ZW'(tor_pkg::PiQ12)) bear = tor_pkg::PiQ12;
    if (zr < -tor_pkg::ZW'(tor_pkg::PiQ12)) bear = -tor_pkg::PiQ12;
    if (v_s.zero) bear = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v_s.valid;
    end
    if (en) begin
      od_r <= {v_s.known, bear[14:0], v_s.rx, v_s.ry};
    end
  end

  assign out_.valid = ov_r;
  assign out_.data  = od_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_.ready |=> ov_r && $stable(od_r))
    else $error("output lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !ov_r |-> in_.ready)
    else $error("input blocked while output empty");
  a_bear: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ($signed(od_r[46:32]) <= 15'sd12868 && $signed(od_r[46:32]) >= -15'sd12868))
    else $error("bearing out of range");
endmodule

>>> design/tor_front.sv
// Front stages: tag match, yaw conversion, angle wrap and quadrant fold.
// Depends on tor_pkg.
module tor_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [9:0]                  tag_id,
  input  logic signed [15:0]          lat,
  input  logic signed [15:0]          fwd,
  input  logic signed [16:0]          yaw,
  input  logic [9:0]                  known_id,
  input  logic signed [15:0]          cfg_tx,
  input  logic signed [15:0]          cfg_ty,
  input  logic signed [14:0]          cfg_th,
  output tor_pkg::rot_stage_t         out_s
);
  logic                v1_r, known1_r;
  logic signed [15:0]  tx1_r, ty1_r, th1_r, lat1_r, fwd1_r;
  logic signed [35:0]  prod1_r;
  logic signed [35:0]  yaw_q12;
  logic signed [19:0]  t_raw, t_wrap;
  logic signed [tor_pkg::ZW-1:0] z0;
  tor_pkg::rot_stage_t s_nxt, s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      known1_r <= (tag_id == known_id);
      tx1_r    <= (tag_id == known_id) ? cfg_tx : 16'sd0;
      ty1_r    <= (tag_id == known_id) ? cfg_ty : 16'sd0;
      th1_r    <= (tag_id == known_id) ? 16'(cfg_th) : 16'sd0;
      lat1_r   <= lat;
      fwd1_r   <= fwd;
      prod1_r  <= 36'(yaw) * 36'(tor_pkg::YawScale);
    end
  end

  always_comb begin
    yaw_q12 = (prod1_r + 36'sd32768) >>> 16;
    t_raw   = 20'(th1_r) + 20'(tor_pkg::PiQ12) - 20'(yaw_q12);
    t_wrap  = t_raw;
    if (t_wrap > 20'(tor_pkg::PiQ12)) t_wrap = t_wrap - 20'(tor_pkg::TwoPiQ12);
    if (t_wrap > 20'(tor_pkg::PiQ12)) t_wrap = t_wrap - 20'(tor_pkg::TwoPiQ12);
    if (t_wrap > 20'(tor_pkg::PiQ12)) t_wrap = t_wrap - 20'(tor_pkg::TwoPiQ12);
    if (t_wrap < -20'(tor_pkg::PiQ12)) t_wrap = t_wrap + 20'(tor_pkg::TwoPiQ12);
    if (t_wrap < -20'(tor_pkg::PiQ12)) t_wrap = t_wrap + 20'(tor_pkg::TwoPiQ12);
    z0 = tor_pkg::ZW'(t_wrap) <<< 8;
    s_nxt       = '0;
    s_nxt.valid = v1_r;
    s_nxt.known = known1_r;
    s_nxt.tx    = tx1_r;
    s_nxt.ty    = ty1_r;
    s_nxt.lat   = lat1_r;
    s_nxt.fwd   = fwd1_r;
    s_nxt.x     = tor_pkg::GainQ16;
    s_nxt.y     = '0;
    s_nxt.z     = z0;
    if (z0 > tor_pkg::HalfPiQ20) begin
      s_nxt.z = z0 - tor_pkg::PiQ20;
      s_nxt.flip = 1'b1;
    end else if (z0 < -tor_pkg::HalfPiQ20) begin
      s_nxt.z = z0 + tor_pkg::PiQ20;
      s_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r.valid <= s_nxt.valid;
    end
    if (en) begin
      s_r.known <= s_nxt.known;
      s_r.tx    <= s_nxt.tx;
      s_r.ty    <= s_nxt.ty;
      s_r.lat   <= s_nxt.lat;
      s_r.fwd   <= s_nxt.fwd;
      s_r.x     <= s_nxt.x;
      s_r.y     <= s_nxt.y;
      s_r.z     <= s_nxt.z;
      s_r.flip  <= s_nxt.flip;
    end
  end

  assign out_s = s_r;
endmodule

>>> design/tor_rotate.sv
// Pipelined rotation CORDIC giving cosine and sine, one stage per iteration.
// Depends on tor_pkg.
module tor_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tor_pkg::rot_stage_t in_s,
  output tor_pkg::rot_stage_t out_s
);
  tor_pkg::rot_stage_t st_r [tor_pkg::NStages+1];

  always_comb st_r[0] = in_s;

  for (genvar i = 0; i < tor_pkg::NStages; i++) begin : g_stage
    tor_pkg::rot_stage_t s_nxt;
    always_comb begin
      s_nxt = st_r[i];
      if (st_r[i].z >= 0) begin
        s_nxt.x = st_r[i].x - (st_r[i].y >>> i);
        s_nxt.y = st_r[i].y + (st_r[i].x >>> i);
        s_nxt.z = st_r[i].z - tor_pkg::atan_q20(i);
      end else begin
        s_nxt.x = st_r[i].x + (st_r[i].y >>> i);
        s_nxt.y = st_r[i].y - (st_r[i].x >>> i);
        s_nxt.z = st_r[i].z + tor_pkg::atan_q20(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i+1].valid <= 1'b0;
      end else if (en) begin
        st_r[i+1].valid <= s_nxt.valid;
      end
      if (en) begin
        st_r[i+1].known <= s_nxt.known;
        st_r[i+1].tx    <= s_nxt.tx;
        st_r[i+1].ty    <= s_nxt.ty;
        st_r[i+1].lat   <= s_nxt.lat;
        st_r[i+1].fwd   <= s_nxt.fwd;
        st_r[i+1].x     <= s_nxt.x;
        st_r[i+1].y     <= s_nxt.y;
        st_r[i+1].z     <= s_nxt.z;
        st_r[i+1].flip  <= s_nxt.flip;
      end
    end
  end

  assign out_s = st_r[tor_pkg::NStages];
endmodule

>>> design/tor_position.sv
// Position stages: four products, rounding, sums with saturation, vector setup.
// Depends on tor_pkg.
module tor_position (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tor_pkg::rot_stage_t in_s,
  output tor_pkg::vec_stage_t out_s
);
  logic                v1_r, known1_r, v2_r, known2_r;
  logic signed [15:0]  tx1_r, ty1_r, tx2_r, ty2_r, rx2_r, ry2_r;
  logic signed [47:0]  fc_r, ls_r, fs_r, lc_r;
  logic signed [31:0]  c, s;
  logic signed [31:0]  fc, ls, fs, lc;
  logic signed [16:0]  dx, dy;
  tor_pkg::vec_stage_t v_nxt, v_r;

  always_comb begin
    c = in_s.flip ? -32'(in_s.x) : 32'(in_s.x);
    s = in_s.flip ? -32'(in_s.y) : 32'(in_s.y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_s.valid;
      v2_r <= v1_r;
    end
    if (en) begin
      known1_r <= in_s.known;
      tx1_r    <= in_s.tx;
      ty1_r    <= in_s.ty;
      fc_r     <= 48'(in_s.fwd) * 48'(c);
      ls_r     <= 48'(in_s.lat) * 48'(s);
      fs_r     <= 48'(in_s.fwd) * 48'(s);
      lc_r     <= 48'(in_s.lat) * 48'(c);
      known2_r <= known1_r;
      tx2_r    <= tx1_r;
      ty2_r    <= ty1_r;
      rx2_r    <= tor_pkg::sat16(20'(-fc + ls) + 20'(tx1_r));
      ry2_r    <= tor_pkg::sat16(20'(-fs - lc) + 20'(ty1_r));
    end
  end

  always_comb begin
    fc = 32'((fc_r + 48'sd32768) >>> 16);
    ls = 32'((ls_r + 48'sd32768) >>> 16);
    fs = 32'((fs_r + 48'sd32768) >>> 16);
    lc = 32'((lc_r + 48'sd32768) >>> 16);
    dx = 17'(tx2_r) - 17'(rx2_r);
    dy = 17'(ty2_r) - 17'(ry2_r);
    v_nxt       = '0;
    v_nxt.valid = v2_r;
    v_nxt.known = known2_r;
    v_nxt.rx    = rx2_r;
    v_nxt.ry    = ry2_r;
    v_nxt.zero  = (dx == 17'sd0) && (dy == 17'sd0);
    v_nxt.x     = tor_pkg::XW'(dx) <<< 8;
    v_nxt.y     = tor_pkg::XW'(dy) <<< 8;
    v_nxt.z     = '0;
    if (dx < 0) begin
      v_nxt.z = (dy >= 0) ? tor_pkg::PiQ20 : -tor_pkg::PiQ20;
      v_nxt.x = -(tor_pkg::XW'(dx) <<< 8);
      v_nxt.y = -(tor_pkg::XW'(dy) <<< 8);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r.valid <= 1'b0;
    end else if (en) begin
      v_r.valid <= v_nxt.valid;
    end
    if (en) begin
      v_r.known <= v_nxt.known;
      v_r.zero  <= v_nxt.zero;
      v_r.x     <= v_nxt.x;
      v_r.y     <= v_nxt.y;
      v_r.z     <= v_nxt.z;
      v_r.rx    <= v_nxt.rx;
      v_r.ry    <= v_nxt.ry;
    end
  end

  assign out_s = v_r;
endmodule

>>> design/tor_vector.sv
// Pipelined vectoring CORDIC giving the bearing angle, one stage per iteration.
// Depends on tor_pkg.
module tor_vector (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tor_pkg::vec_stage_t in_s,
  output tor_pkg::vec_stage_t out_s
);
  tor_pkg::vec_stage_t st_r [tor_pkg::NStages+1];

  always_comb st_r[0] = in_s;

  for (genvar i = 0; i < tor_pkg::NStages; i++) begin : g_stage
    tor_pkg::vec_stage_t s_nxt;
    always_comb begin
      s_nxt = st_r[i];
      if (st_r[i].y > 0) begin
        s_nxt.x = st_r[i].x + (st_r[i].y >>> i);
        s_nxt.y = st_r[i].y - (st_r[i].x >>> i);
        s_nxt.z = st_r[i].z + tor_pkg::atan_q20(i);
      end else begin
        s_nxt.x = st_r[i].x - (st_r[i].y >>> i);
        s_nxt.y = st_r[i].y + (st_r[i].x >>> i);
        s_nxt.z = st_r[i].z - tor_pkg::atan_q20(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i+1].valid <= 1'b0;
      end else if (en) begin
        st_r[i+1].valid <= s_nxt.valid;
      end
      if (en) begin
        st_r[i+1].known <= s_nxt.known;
        st_r[i+1].zero  <= s_nxt.zero;
        st_r[i+1].x     <= s_nxt.x;
        st_r[i+1].y     <= s_nxt.y;
        st_r[i+1].z     <= s_nxt.z;
        st_r[i+1].rx    <= s_nxt.rx;
        st_r[i+1].ry    <= s_nxt.ry;
      end
    end
  end

  assign out_s = st_r[tor_pkg::NStages];
endmodule
